FILE: src/tcwrs_pkg.sv
// Package for the two-class weighted request scheduler.
// Holds widths, queue depth, codes and the pointer wrap helper.
// No dependencies.
package tcwrs_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = ADDR_W + 1;

   // Payload widths
   localparam int TAG_W       = 16;
   localparam int THR_W       = 8;
   localparam int CLASS_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int WEIGHT_W    = 4;
   localparam int RUN_W       = 4;

   // Premium entries keep one class bit (premium vs. unlimited)
   localparam int P_ENTRY_W   = 1 + TAG_W + THR_W;
   localparam int F_ENTRY_W   = TAG_W + THR_W;

   // Control register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = WEIGHT_W;

   localparam logic [RUN_W-1:0]    RUN_MAX   = 4'hF;
   localparam logic [WEIGHT_W-1:0] PW_RESET  = 4'd4;
   localparam logic [WEIGHT_W-1:0] FW_RESET  = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PREMIUM_WEIGHT,
      REG_FREE_WEIGHT
   } csr_reg_type;

   typedef enum logic {
      REQ_ENQUEUE,
      REQ_SERVE
   } req_kind_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_FREE,
      CLS_PREMIUM,
      CLS_UNLIMITED,
      CLS_INVALID
   } class_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED,
      ST_INVALID,
      ST_FULL,
      ST_GRANTED,
      ST_EMPTY
   } status_type;

   // head + fill, folded back into the ring (sum stays below twice the depth)
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] head,
                                                 input logic [FILL_W-1:0] fill);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + SUM_W'(fill);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // Advance a head pointer by one with wrap
   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] head);
      logic [ADDR_W-1:0] nxt;
      if (head == ADDR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = head + ADDR_W'(1);
      end
      return nxt;
   endfunction

endpackage

FILE: src/tcwrs_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on tcwrs_pkg for field widths.
interface tcwrs_req_if import tcwrs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [CLASS_W-1:0] user_class;
   logic [TAG_W-1:0]   request_tag;
   logic [THR_W-1:0]   thread_count;

   modport source (output valid, req_type, user_class, request_tag, thread_count,
                   input ready);
   modport sink   (input valid, req_type, user_class, request_tag, thread_count,
                   output ready);
endinterface

interface tcwrs_rsp_if import tcwrs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CLASS_W-1:0]  granted_class;
   logic [TAG_W-1:0]    granted_tag;
   logic [THR_W-1:0]    granted_threads;

   modport source (output valid, status, granted_class, granted_tag, granted_threads,
                   input ready);
   modport sink   (input valid, status, granted_class, granted_tag, granted_threads,
                   output ready);
endinterface

FILE: src/tcwrs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcwrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/two_class_weighted_request_scheduler.sv
// Two-class weighted request scheduler: premium and free request FIFOs in RAM.
// Depends on tcwrs_pkg, tcwrs_if (req/rsp channels) and tcwrs_ram.
//
// Takes one item per cycle unless a response stall holds the pending stage, and returns
// exactly one result per item, in order. An enqueue writes its FIFO memory at the
// acceptance edge; a serve picks the class from the fill and run registers and reads the
// head entry through the registered RAM read port. Each result moves from the pending
// stage into the response register once that register is free or draining. A one-entry
// pending stage plus the response register let the next request transfer while a result
// still waits. Premium requests are granted while the premium run count is below the
// premium weight (or no free request waits), free ones under the mirrored rule, premium
// winning when both qualify; a full FIFO refuses with status "queue full", an invalid class
// gets status invalid and is not queued. Weights reset to 4 and 1; the user must write
// them through the csr port only while the block is idle; the block does not enforce it.
// The memories need no clearing after reset: only written entries are ever read.
module two_class_weighted_request_scheduler import tcwrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   tcwrs_req_if.sink              req_chan,
   tcwrs_rsp_if.source            rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_PREMIUM,
      SRC_FREE
   } src_type;

   // Control registers
   logic [WEIGHT_W-1:0] pw_ff, pw_in;
   logic [WEIGHT_W-1:0] fw_ff, fw_in;

   // FIFO pointers and run counters
   logic [ADDR_W-1:0] p_head_ff, p_head_in;
   logic [FILL_W-1:0] p_fill_ff, p_fill_in;
   logic [ADDR_W-1:0] f_head_ff, f_head_in;
   logic [FILL_W-1:0] f_fill_ff, f_fill_in;
   logic [RUN_W-1:0]  p_run_ff, p_run_in;
   logic [RUN_W-1:0]  f_run_ff, f_run_in;

   // Pending stage (waits for RAM read data)
   logic       s1_valid_ff, s1_valid_in;
   status_type s1_status_ff, s1_status_in;
   src_type    s1_src_ff, s1_src_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CLASS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [THR_W-1:0]    rsp_thr_ff, rsp_thr_in;

   // Decode
   logic       s2_load, s1_open, accept;
   logic       p_push, f_push, p_pop, f_pop;
   logic       p_rdy, f_rdy, p_full, f_full, grant_p, grant_f;
   status_type dec_status;
   src_type    dec_src;

   // RAM ports
   logic [P_ENTRY_W-1:0] p_rd_data;
   logic [F_ENTRY_W-1:0] f_rd_data;

   // Handshake: pending stage moves on when the response register is free or draining
   assign s2_load        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s1_open        = !s1_valid_ff || s2_load;
   assign req_chan.ready = s1_open;
   assign accept         = req_chan.valid && s1_open;

   // Grant rules
   assign p_rdy   = (p_fill_ff != '0);
   assign f_rdy   = (f_fill_ff != '0);
   assign p_full  = (p_fill_ff == FILL_W'(QUEUE_DEPTH));
   assign f_full  = (f_fill_ff == FILL_W'(QUEUE_DEPTH));
   assign grant_p = p_rdy && ((p_run_ff < pw_ff) || !f_rdy);
   assign grant_f = !grant_p && f_rdy && ((f_run_ff < fw_ff) || !p_rdy);

   // Item decode
   always_comb begin
      p_push     = 1'b0;
      f_push     = 1'b0;
      p_pop      = 1'b0;
      f_pop      = 1'b0;
      dec_status = ST_EMPTY;
      dec_src    = SRC_NONE;
      if (req_chan.req_type == REQ_ENQUEUE) begin
         unique case (req_chan.user_class)
            CLS_FREE: begin
               dec_status = f_full ? ST_FULL : ST_QUEUED;
               f_push     = accept && !f_full;
            end
            CLS_PREMIUM, CLS_UNLIMITED: begin
               dec_status = p_full ? ST_FULL : ST_QUEUED;
               p_push     = accept && !p_full;
            end
            default: begin
               dec_status = ST_INVALID;
            end
         endcase
      end else begin
         priority if (grant_p) begin
            dec_status = ST_GRANTED;
            dec_src    = SRC_PREMIUM;
            p_pop      = accept;
         end else if (grant_f) begin
            dec_status = ST_GRANTED;
            dec_src    = SRC_FREE;
            f_pop      = accept;
         end else begin
            dec_status = ST_EMPTY;
         end
      end
   end

   // Next state of pointers, fills, run counters and weights
   always_comb begin
      pw_in     = pw_ff;
      fw_in     = fw_ff;
      p_head_in = p_head_ff;
      p_fill_in = p_fill_ff;
      f_head_in = f_head_ff;
      f_fill_in = f_fill_ff;
      p_run_in  = p_run_ff;
      f_run_in  = f_run_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_PREMIUM_WEIGHT: pw_in = csr_wdata;
            REG_FREE_WEIGHT:    fw_in = csr_wdata;
            default: ;
         endcase
      end

      if (p_push) begin
         p_fill_in = p_fill_ff + FILL_W'(1);
      end
      if (f_push) begin
         f_fill_in = f_fill_ff + FILL_W'(1);
      end
      if (p_pop) begin
         p_head_in = ring_next(p_head_ff);
         p_fill_in = p_fill_ff - FILL_W'(1);
         p_run_in  = (p_run_ff == RUN_MAX) ? RUN_MAX : p_run_ff + RUN_W'(1);
         f_run_in  = '0;
      end
      if (f_pop) begin
         f_head_in = ring_next(f_head_ff);
         f_fill_in = f_fill_ff - FILL_W'(1);
         f_run_in  = (f_run_ff == RUN_MAX) ? RUN_MAX : f_run_ff + RUN_W'(1);
         p_run_in  = '0;
      end
   end

   // Pending stage and response register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_status_in = s1_status_ff;
      s1_src_in    = s1_src_ff;
      if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_status_in = dec_status;
         s1_src_in    = dec_src;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_thr_in    = rsp_thr_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = s1_status_ff;
         unique case (s1_src_ff)
            SRC_PREMIUM: begin
               rsp_class_in = p_rd_data[P_ENTRY_W-1] ? CLS_UNLIMITED : CLS_PREMIUM;
               rsp_tag_in   = p_rd_data[THR_W +: TAG_W];
               rsp_thr_in   = p_rd_data[THR_W-1:0];
            end
            SRC_FREE: begin
               rsp_class_in = CLS_FREE;
               rsp_tag_in   = f_rd_data[THR_W +: TAG_W];
               rsp_thr_in   = f_rd_data[THR_W-1:0];
            end
            default: begin
               rsp_class_in = '0;
               rsp_tag_in   = '0;
               rsp_thr_in   = '0;
            end
         endcase
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff        <= PW_RESET;
         fw_ff        <= FW_RESET;
         p_head_ff    <= '0;
         p_fill_ff    <= '0;
         f_head_ff    <= '0;
         f_fill_ff    <= '0;
         p_run_ff     <= '0;
         f_run_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pw_ff        <= pw_in;
         fw_ff        <= fw_in;
         p_head_ff    <= p_head_in;
         p_fill_ff    <= p_fill_in;
         f_head_ff    <= f_head_in;
         f_fill_ff    <= f_fill_in;
         p_run_ff     <= p_run_in;
         f_run_ff     <= f_run_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_status_ff  <= s1_status_in;
      s1_src_ff     <= s1_src_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_thr_ff    <= rsp_thr_in;
   end

   // FIFO memories; a push never lands on a live entry, so no forwarding is needed
   tcwrs_ram #(
      .WIDTH (P_ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_premium_ram (
      .clock   (clock),
      .wr_en   (p_push),
      .wr_addr (ring_add(p_head_ff, p_fill_ff)),
      .wr_data ({req_chan.user_class[1], req_chan.request_tag, req_chan.thread_count}),
      .rd_en   (p_pop),
      .rd_addr (p_head_ff),
      .rd_data (p_rd_data)
   );

   tcwrs_ram #(
      .WIDTH (F_ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (f_push),
      .wr_addr (ring_add(f_head_ff, f_fill_ff)),
      .wr_data ({req_chan.request_tag, req_chan.thread_count}),
      .rd_en   (f_pop),
      .rd_addr (f_head_ff),
      .rd_data (f_rd_data)
   );

   // Response outputs
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_class   = rsp_class_ff;
   assign rsp_chan.granted_tag     = rsp_tag_ff;
   assign rsp_chan.granted_threads = rsp_thr_ff;

endmodule
